// File: rtl/core/ptat_pkg.sv
`default_nettype none
package ptat_pkg;

  // item operation codes
  localparam logic [1:0] OP_OBS   = 2'd0;
  localparam logic [1:0] OP_EOF   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_CROWD_LIMIT = 3'd0;
  localparam logic [2:0] REG_CROWD_NUMER = 3'd1;
  localparam logic [2:0] REG_LOOSE_DIST  = 3'd2;
  localparam logic [2:0] REG_TIGHT_DIST  = 3'd3;
  localparam logic [2:0] REG_COLOR_LIMIT = 3'd4;

  localparam int PADDR_W = 5;

  // register reset values
  localparam logic [23:0] CROWD_LIMIT_RST = 24'd13107;
  localparam logic [15:0] CROWD_NUMER_RST = 16'd500;
  localparam logic [29:0] LOOSE_DIST_RST  = 30'd10000;
  localparam logic [29:0] TIGHT_DIST_RST  = 30'd2500;
  localparam logic [17:0] COLOR_LIMIT_RST = 18'd300;

  localparam logic [23:0] SCORE_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] obs_x;
    logic signed [15:0] obs_y;
    logic signed [15:0] obs_z;
    logic [7:0]         obs_red;
    logic [7:0]         obs_green;
    logic [7:0]         obs_blue;
    logic [15:0]        box_x;
    logic [15:0]        box_y;
    logic [15:0]        box_z;
  } item_t;

  typedef struct packed {
    logic [15:0] track_id;
    logic        is_new;
    logic [4:0]  match_count;
    logic [4:0]  removed_count;
    logic [4:0]  live_tracks;
    logic        table_full;
  } result_t;

  // stored track fields except the id
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [15:0] bx;
    logic [15:0] by;
    logic [15:0] bz;
  } track_rec_t;

  localparam int REC_W = $bits(track_rec_t);

endpackage
`default_nettype wire

// File: rtl/core/person_track_association_table_core.sv
`default_nettype none
// channel   | signals                          | transfer when
// item      | item_valid, item_ready, item     | item_valid && item_ready
// result    | result_valid, result_ready, result | result_valid && result_ready
// config    | psel penable pwrite paddr pwdata | psel && penable && pwrite
//
// an observation scans the table twice; on the first scan a live track that
// differs from the observation in x and z also runs the crowd unit (17 root
// steps and 32 divide steps), and the second scan checks each track for a match.
// end of frame compacts the table in one pass over the live tracks;
// an empty frame end, a clear or an unknown op goes straight to the result.
// reset is synchronous and empties the table; no memory sweep is needed.
// a new item is taken while the previous result waits to be read.
module person_track_association_table_core #(
  parameter int MAX_TRACKS = 16,
  parameter int ID_BITS    = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     item_valid,
  output logic                          item_ready,
  input  wire ptat_pkg::item_t          item,
  output logic                          result_valid,
  input  wire logic                     result_ready,
  output ptat_pkg::result_t             result,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [ptat_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]              pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ptat_pkg::*;

  localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = $clog2(MAX_TRACKS + 1);
  localparam int RW = REC_W + ID_BITS;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TRACKS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_P1_RD  = 4'd1;
  localparam logic [3:0] S_P1_SUB = 4'd2;
  localparam logic [3:0] S_P1_SQ  = 4'd3;
  localparam logic [3:0] S_P1_GO  = 4'd4;
  localparam logic [3:0] S_P1_WT  = 4'd5;
  localparam logic [3:0] S_P2_RD  = 4'd6;
  localparam logic [3:0] S_P2_SUB = 4'd7;
  localparam logic [3:0] S_P2_SQ  = 4'd8;
  localparam logic [3:0] S_P2_HIT = 4'd9;
  localparam logic [3:0] S_ADD    = 4'd10;
  localparam logic [3:0] S_EF_RD  = 4'd11;
  localparam logic [3:0] S_EF_CHK = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  // configuration registers
  logic [23:0] crowd_limit;
  logic [15:0] crowd_numerator;
  logic [29:0] loose_dist_sq;
  logic [29:0] tight_dist_sq;
  logic [17:0] color_dist_limit;

  // block state
  logic [3:0]            state;
  logic [CW-1:0]         live;
  logic [MAX_TRACKS-1:0] seen;
  logic [ID_BITS-1:0]    next_ident;
  logic                  frame_had_obs;

  // per item working registers
  item_t                 cur;
  logic [AW-1:0]         idx;
  logic [CW-1:0]         kept;
  logic [23:0]           score;
  logic                  loose;
  logic                  found;
  logic [ID_BITS-1:0]    tid;
  logic                  is_new;
  logic [CW-1:0]         mcount;
  logic [CW-1:0]         rcount;
  logic                  full;
  logic signed [16:0]    dx;
  logic signed [16:0]    dz;
  logic signed [8:0]     er;
  logic signed [8:0]     eg;
  logic signed [8:0]     eb;
  logic                  nz;
  logic [ID_BITS-1:0]    rec_ident;
  logic [32:0]           d2;
  logic [17:0]           c2;

  // memory port
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [RW-1:0]         wdata;
  logic [RW-1:0]         rdata;
  track_rec_t            rd_rec;
  track_rec_t            obs_rec;

  // crowd term unit
  logic                  crowd_start;
  logic                  crowd_done;
  logic [31:0]           crowd_term;

  // helper terms
  logic signed [33:0]    sqx;
  logic signed [33:0]    sqz;
  logic signed [17:0]    sqr;
  logic signed [17:0]    sqg;
  logic signed [17:0]    sqb;
  logic [CW-1:0]         idx_ext;
  logic                  last;
  logic                  hit;
  logic [32:0]           score_sum;
  logic [CW-1:0]         kept_next;
  logic [ID_BITS+15:0]   tid_ext;
  logic                  cfg_we;

  ptat_ram #(.WIDTH(RW), .DEPTH(MAX_TRACKS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx),
    .rdata (rdata)
  );

  ptat_crowd u_crowd (
    .clk   (clk),
    .rst   (rst),
    .start (crowd_start),
    .d2    (d2),
    .numer (crowd_numerator),
    .done  (crowd_done),
    .term  (crowd_term)
  );

  // configuration access
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:2])
      REG_CROWD_LIMIT: prdata = {8'd0, crowd_limit};
      REG_CROWD_NUMER: prdata = {16'd0, crowd_numerator};
      REG_LOOSE_DIST:  prdata = {2'd0, loose_dist_sq};
      REG_TIGHT_DIST:  prdata = {2'd0, tight_dist_sq};
      REG_COLOR_LIMIT: prdata = {14'd0, color_dist_limit};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crowd_limit      <= CROWD_LIMIT_RST;
      crowd_numerator  <= CROWD_NUMER_RST;
      loose_dist_sq    <= LOOSE_DIST_RST;
      tight_dist_sq    <= TIGHT_DIST_RST;
      color_dist_limit <= COLOR_LIMIT_RST;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_CROWD_LIMIT: crowd_limit      <= pwdata[23:0];
        REG_CROWD_NUMER: crowd_numerator  <= pwdata[15:0];
        REG_LOOSE_DIST:  loose_dist_sq    <= pwdata[29:0];
        REG_TIGHT_DIST:  tight_dist_sq    <= pwdata[29:0];
        REG_COLOR_LIMIT: color_dist_limit <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  // combinational helpers
  always_comb begin
    rd_rec      = track_rec_t'(rdata[REC_W-1:0]);
    obs_rec     = '{x: cur.obs_x, y: cur.obs_y, z: cur.obs_z,
                    r: cur.obs_red, g: cur.obs_green, b: cur.obs_blue,
                    bx: cur.box_x, by: cur.box_y, bz: cur.box_z};
    sqx         = dx * dx;
    sqz         = dz * dz;
    sqr         = er * er;
    sqg         = eg * eg;
    sqb         = eb * eb;
    idx_ext     = CW'(idx);
    last        = (idx_ext + CW'(1)) == live;
    hit         = loose ? (d2 < {3'd0, loose_dist_sq})
                        : ((d2 < {3'd0, tight_dist_sq}) && (c2 < color_dist_limit));
    score_sum   = {9'd0, score} + {1'b0, crowd_term};
    kept_next   = seen[idx] ? kept + CW'(1) : kept;
    crowd_start = (state == S_P1_GO) && nz;
    item_ready  = (state == S_IDLE);
    tid_ext     = {16'd0, tid};
    we          = 1'b0;
    waddr       = idx;
    wdata       = {rec_ident, obs_rec};
    case (state)
      S_P2_HIT: we = hit;
      S_ADD: begin
        we    = !found && (live < MAX_CNT);
        waddr = live[AW-1:0];
        wdata = {next_ident, obs_rec};
      end
      S_EF_CHK: begin
        we    = seen[idx];
        waddr = kept[AW-1:0];
        wdata = rdata;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      live          <= '0;
      seen          <= '0;
      next_ident    <= '0;
      frame_had_obs <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur    <= item;
            idx    <= '0;
            kept   <= '0;
            score  <= '0;
            found  <= 1'b0;
            tid    <= '0;
            is_new <= 1'b0;
            mcount <= '0;
            rcount <= '0;
            full   <= 1'b0;
            case (item.op)
              OP_OBS: begin
                frame_had_obs <= 1'b1;
                loose         <= 1'b1;
                state         <= (live == '0) ? S_ADD : S_P1_RD;
              end
              OP_EOF: begin
                frame_had_obs <= 1'b0;
                if (!frame_had_obs || live == '0) begin
                  rcount <= live;
                  live   <= '0;
                  seen   <= '0;
                  state  <= S_DONE;
                end else begin
                  state <= S_EF_RD;
                end
              end
              OP_CLEAR: begin
                frame_had_obs <= 1'b0;
                rcount        <= live;
                live          <= '0;
                seen          <= '0;
                state         <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        // crowd score scan
        S_P1_RD: state <= S_P1_SUB;
        S_P1_SUB: begin
          dx    <= {rd_rec.x[15], rd_rec.x} - {cur.obs_x[15], cur.obs_x};
          dz    <= {rd_rec.z[15], rd_rec.z} - {cur.obs_z[15], cur.obs_z};
          nz    <= (rd_rec.x != cur.obs_x) && (rd_rec.z != cur.obs_z);
          state <= S_P1_SQ;
        end
        S_P1_SQ: begin
          d2    <= {1'b0, sqx[31:0]} + {1'b0, sqz[31:0]};
          state <= S_P1_GO;
        end
        S_P1_GO: begin
          if (nz) begin
            state <= S_P1_WT;
          end else if (last) begin
            idx   <= '0;
            loose <= score < crowd_limit;
            state <= S_P2_RD;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_P1_RD;
          end
        end
        S_P1_WT: begin
          if (crowd_done) begin
            if (score_sum > {9'd0, SCORE_MAX}) begin
              score <= SCORE_MAX;
              loose <= SCORE_MAX < crowd_limit;
            end else begin
              score <= score_sum[23:0];
              loose <= score_sum[23:0] < crowd_limit;
            end
            if (last) begin
              idx   <= '0;
              state <= S_P2_RD;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_P1_RD;
            end
          end
        end
        // matching scan
        S_P2_RD: state <= S_P2_SUB;
        S_P2_SUB: begin
          dx        <= {rd_rec.x[15], rd_rec.x} - {cur.obs_x[15], cur.obs_x};
          dz        <= {rd_rec.z[15], rd_rec.z} - {cur.obs_z[15], cur.obs_z};
          er        <= {1'b0, cur.obs_red} - {1'b0, rd_rec.r};
          eg        <= {1'b0, cur.obs_green} - {1'b0, rd_rec.g};
          eb        <= {1'b0, cur.obs_blue} - {1'b0, rd_rec.b};
          rec_ident <= rdata[RW-1:REC_W];
          state     <= S_P2_SQ;
        end
        S_P2_SQ: begin
          d2    <= {1'b0, sqx[31:0]} + {1'b0, sqz[31:0]};
          c2    <= {2'd0, sqr[15:0]} + {2'd0, sqg[15:0]} + {2'd0, sqb[15:0]};
          state <= S_P2_HIT;
        end
        S_P2_HIT: begin
          if (hit) begin
            seen[idx] <= 1'b1;
            found     <= 1'b1;
            mcount    <= mcount + CW'(1);
            if (!found) begin
              tid <= rec_ident;
            end
          end
          if (last) begin
            state <= S_ADD;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_P2_RD;
          end
        end
        // append when nothing matched and the table has room, else flag it full
        S_ADD: begin
          if (!found) begin
            if (live < MAX_CNT) begin
              seen[live[AW-1:0]] <= 1'b1;
              live               <= live + CW'(1);
              tid                <= next_ident;
              is_new             <= 1'b1;
              next_ident         <= next_ident + ID_BITS'(1);
            end else begin
              full <= 1'b1;
            end
          end
          state <= S_DONE;
        end
        // end of frame compaction
        S_EF_RD: state <= S_EF_CHK;
        S_EF_CHK: begin
          kept <= kept_next;
          if (!seen[idx]) begin
            rcount <= rcount + CW'(1);
          end
          if (last) begin
            live  <= kept_next;
            seen  <= '0;
            state <= S_DONE;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_EF_RD;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid         <= 1'b1;
            result.track_id      <= tid_ext[15:0];
            result.is_new        <= is_new;
            result.match_count   <= 5'(mcount);
            result.removed_count <= 5'(rcount);
            result.live_tracks   <= 5'(live);
            result.table_full    <= full;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/ptat_ram.sv
`default_nettype none
module ptat_ram #(
  parameter int WIDTH = 136,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/core/ptat_crowd.sv
`default_nettype none
module ptat_crowd (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [32:0] d2,
  input  wire logic [15:0] numer,
  output logic             done,
  output logic [31:0]      term
);
  import ptat_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_SQRT = 2'd1;
  localparam logic [1:0] C_DIV  = 2'd2;

  logic [1:0]  st;
  logic [4:0]  cnt;
  logic [33:0] rad;
  logic [18:0] srem;
  logic [16:0] root;
  logic [31:0] dvd;
  logic [16:0] drem;
  logic [18:0] s_try;
  logic [18:0] s_trial;
  logic [17:0] d_try;
  logic [16:0] divisor;

  // one root bit per cycle, then one quotient bit per cycle
  always_comb begin
    s_try   = {srem[16:0], rad[33:32]};
    s_trial = {root, 2'b01};
    divisor = (root == '0) ? 17'd1 : root;
    d_try   = {drem, dvd[31]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= C_IDLE;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      case (st)
        C_IDLE: begin
          if (start) begin
            rad  <= {1'b0, d2};
            srem <= '0;
            root <= '0;
            cnt  <= '0;
            st   <= C_SQRT;
          end
        end
        C_SQRT: begin
          rad <= {rad[31:0], 2'b00};
          if (s_try >= s_trial) begin
            srem <= s_try - s_trial;
            root <= {root[15:0], 1'b1};
          end else begin
            srem <= s_try;
            root <= {root[15:0], 1'b0};
          end
          if (cnt == 5'd16) begin
            cnt  <= '0;
            dvd  <= {numer, 16'd0};
            drem <= '0;
            st   <= C_DIV;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        C_DIV: begin
          dvd <= {dvd[30:0], 1'b0};
          if (d_try >= {1'b0, divisor}) begin
            drem <= 17'(d_try - {1'b0, divisor});
            term <= {term[30:0], 1'b1};
          end else begin
            drem <= d_try[16:0];
            term <= {term[30:0], 1'b0};
          end
          if (cnt == 5'd31) begin
            done <= 1'b1;
            st   <= C_IDLE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        default: st <= C_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sim/person_track_association_table_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module person_track_association_table_core_tb;
  import ptat_pkg::*;

  localparam int N_TRACKS = 16;
  localparam int CYCLE_LIMIT = 4000000;

  // one stored track in the predictor
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] z;
    logic [7:0]         r;
    logic [7:0]         g;
    logic [7:0]         b;
    logic [15:0]        ident;
    bit                 seen;
  } person_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  person_track_association_table_core i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // predictor state
  person_t people[$];
  logic [15:0] next_person_id = '0;
  bit frame_busy = 0;
  logic [23:0] crowd_limit_q = CROWD_LIMIT_RST;
  logic [15:0] crowd_numer_q = CROWD_NUMER_RST;
  logic [29:0] loose_dist_q = LOOSE_DIST_RST;
  logic [29:0] tight_dist_q = TIGHT_DIST_RST;
  logic [17:0] color_limit_q = COLOR_LIMIT_RST;

  item_t pending_items[$];
  result_t expected_results[$];
  int mismatches = 0;
  int accepted_items = 0;
  int checked_results = 0;
  int new_tracks = 0;
  int full_hits = 0;
  int crowded_obs = 0;
  int cycles = 0;
  bit hold_sender = 0;
  int burst_left = 0;
  int gap_left = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    root = 0;
    for (int k = 31; k >= 0; k--)
      if ((root | (64'd1 << k)) * (root | (64'd1 << k)) <= n)
        root = root | (64'd1 << k);
    return root;
  endfunction

  // work out the result of one item and update the track table
  function automatic result_t predict_association(item_t it);
    result_t res;
    longint signed dx, dz;
    longint unsigned d2, s, score, c2;
    int er, eg, eb;
    bit loose, found, hit;
    person_t kept[$];
    person_t fresh;
    res = '0;
    if (it.op == OP_OBS) begin
      frame_busy = 1;
      score = 0;
      foreach (people[i]) begin
        dx = longint'(people[i].x) - longint'(it.obs_x);
        dz = longint'(people[i].z) - longint'(it.obs_z);
        if (dx != 0 && dz != 0) begin
          s = int_sqrt(dx * dx + dz * dz);
          if (s == 0) s = 1;
          score += (longint'(crowd_numer_q) << 16) / s;
          if (score > 64'hFFFFFF) score = 64'hFFFFFF;
        end
      end
      loose = score < crowd_limit_q;
      if (!loose) crowded_obs++;
      found = 0;
      foreach (people[i]) begin
        dx = longint'(people[i].x) - longint'(it.obs_x);
        dz = longint'(people[i].z) - longint'(it.obs_z);
        d2 = dx * dx + dz * dz;
        if (loose) hit = d2 < loose_dist_q;
        else begin
          er = int'(it.obs_red) - int'(people[i].r);
          eg = int'(it.obs_green) - int'(people[i].g);
          eb = int'(it.obs_blue) - int'(people[i].b);
          c2 = er * er + eg * eg + eb * eb;
          hit = d2 < tight_dist_q && c2 < color_limit_q;
        end
        if (hit) begin
          if (!found) res.track_id = people[i].ident;
          found = 1;
          res.match_count++;
          people[i].x = it.obs_x;
          people[i].z = it.obs_z;
          people[i].r = it.obs_red;
          people[i].g = it.obs_green;
          people[i].b = it.obs_blue;
          people[i].seen = 1;
        end
      end
      if (!found) begin
        if (people.size() < N_TRACKS) begin
          fresh = '{it.obs_x, it.obs_z, it.obs_red, it.obs_green, it.obs_blue,
                    next_person_id, 1'b1};
          people = {people, fresh};
          res.track_id = next_person_id;
          res.is_new = 1;
          next_person_id++;
          new_tracks++;
        end else begin
          res.table_full = 1;
          full_hits++;
        end
      end
    end else if (it.op == OP_EOF) begin
      if (!frame_busy) begin
        res.removed_count = 5'(people.size());
        people.delete();
      end else begin
        foreach (people[i])
          if (people[i].seen) begin
            people[i].seen = 0;
            kept = {kept, people[i]};
          end else res.removed_count++;
        people = kept;
      end
      frame_busy = 0;
    end else if (it.op == OP_CLEAR) begin
      res.removed_count = 5'(people.size());
      people.delete();
      frame_busy = 0;
    end
    res.live_tracks = 5'(people.size());
    return res;
  endfunction

  bit item_ready_seen = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && item_valid && item_ready) begin
      expected_results = {expected_results, predict_association(item)};
      accepted_items <= accepted_items + 1;
    end
    item_ready_seen <= item_valid && item_ready;
  end

  // sender: bursts with random gaps
  always @(negedge clk) begin
    if (!rst) begin
      if (!item_valid || item_ready_seen) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (!hold_sender && pending_items.size() > 0) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else burst_left <= burst_left - 1;
        end else item_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern of its own
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if ((stall_phase / 200) % 3 == 0) result_ready <= 1'b1;
    else result_ready <= ($urandom_range(0, 99) < 60);
  end

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result %p", result);
      end else begin
        exp_res = expected_results.pop_front();
        checked_results <= checked_results + 1;
        if (result.track_id !== exp_res.track_id || result.is_new !== exp_res.is_new
            || result.match_count !== exp_res.match_count
            || result.removed_count !== exp_res.removed_count
            || result.live_tracks !== exp_res.live_tracks
            || result.table_full !== exp_res.table_full) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("result mismatch: expected %p actual %p", exp_res, result);
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("person_track_association_table_core_tb failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2; pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CROWD_LIMIT: crowd_limit_q = value[23:0];
      REG_CROWD_NUMER: crowd_numer_q = value[15:0];
      REG_LOOSE_DIST:  loose_dist_q = value[29:0];
      REG_TIGHT_DIST:  tight_dist_q = value[29:0];
      default:         color_limit_q = value[17:0];
    endcase
  endtask

  // wait until everything sent has been checked, then let the block settle
  task automatic drain();
    while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (1200) @(posedge clk);
  endtask

  function automatic item_t make_item(logic [1:0] op, int x, int z, int col);
    item_t it;
    it = '0;
    it.op = op;
    it.obs_x = 16'(x); it.obs_z = 16'(z);
    it.obs_y = 16'($urandom);
    it.obs_red = 8'(col); it.obs_green = 8'(col + 7); it.obs_blue = 8'(col + 13);
    it.box_x = 16'($urandom); it.box_y = 16'($urandom); it.box_z = 16'($urandom);
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it = make_item(OP_OBS, $urandom_range(0, 12) * 60 - 360,
                   $urandom_range(0, 12) * 60 - 360, $urandom_range(0, 255));
    if (pick < 3) it = make_item(OP_OBS, $urandom, $urandom, $urandom);
    if (pick >= 3 && pick < 10) begin
      it.obs_red = 8'($urandom); it.obs_green = 8'($urandom); it.obs_blue = 8'($urandom);
    end
    if (pick >= 80 && pick < 93) it.op = OP_EOF;
    else if (pick >= 93 && pick < 96) it.op = OP_CLEAR;
    else if (pick >= 96) it.op = 2'd3;
    return it;
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, every op, empty frame, full table, ignored op
    pending_items = {pending_items, make_item(OP_EOF, 0, 0, 0)};
    pending_items = {pending_items, make_item(OP_OBS, -32768, -32768, 0)};
    pending_items = {pending_items, make_item(OP_OBS, 32767, 32767, 255)};
    pending_items = {pending_items, make_item(OP_OBS, 32767, 32767, 255)};
    pending_items = {pending_items, make_item(OP_OBS, 32767, 100, 40)};
    pending_items = {pending_items, make_item(2'd3, 5, 5, 5)};
    pending_items = {pending_items, make_item(OP_EOF, 0, 0, 0)};
    pending_items = {pending_items, make_item(OP_EOF, 0, 0, 0)};
    for (int i = 0; i < 17; i++)
      pending_items = {pending_items, make_item(OP_OBS, i * 1000 - 8000, i * 900, i * 15)};
    pending_items = {pending_items, make_item(OP_CLEAR, 0, 0, 0)};
    hold_sender = 0;
    drain();

    // walk several register settings, extremes included
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_CROWD_LIMIT, 32'hFFFFFF); write_reg(REG_CROWD_NUMER, 0);
          write_reg(REG_LOOSE_DIST, 32'h3FFFFFFF); write_reg(REG_TIGHT_DIST, 0);
          write_reg(REG_COLOR_LIMIT, 0);
        end
        1: begin
          write_reg(REG_CROWD_LIMIT, 0); write_reg(REG_CROWD_NUMER, 32'hFFFF);
          write_reg(REG_TIGHT_DIST, 32'h3FFFFFFF); write_reg(REG_COLOR_LIMIT, 32'h3FFFF);
        end
        2: begin
          write_reg(REG_CROWD_LIMIT, 32'(CROWD_LIMIT_RST)); write_reg(REG_CROWD_NUMER, 500);
          write_reg(REG_LOOSE_DIST, 10000); write_reg(REG_TIGHT_DIST, 2500);
          write_reg(REG_COLOR_LIMIT, 300);
        end
        3: begin
          write_reg(REG_CROWD_LIMIT, $urandom_range(1000, 200000));
          write_reg(REG_CROWD_NUMER, $urandom_range(100, 4000));
          write_reg(REG_LOOSE_DIST, $urandom_range(1000, 40000));
          write_reg(REG_TIGHT_DIST, $urandom_range(500, 20000));
          write_reg(REG_COLOR_LIMIT, $urandom_range(100, 195075));
        end
        4: write_reg(REG_LOOSE_DIST, 0);
        default: write_reg(REG_CROWD_LIMIT, 20000);
      endcase
      for (int i = 0; i < 170; i++) pending_items = {pending_items, random_item()};
      if (phase == 3) begin
        // sender stops mid-stream until the block has caught up
        repeat (400) @(posedge clk);
        hold_sender = 1;
        while (expected_results.size() > 0 || item_valid) @(posedge clk);
        hold_sender = 0;
      end
      drain();
    end

    $display("%0d items, %0d results checked, %0d new tracks, %0d full-table hits",
             accepted_items, checked_results, new_tracks, full_hits);
    $display("%0d observations took the crowded rule", crowded_obs);
    if (mismatches == 0) $display("person_track_association_table_core_tb passed");
    else $display("person_track_association_table_core_tb failed");
    $finish;
  end
endmodule

// File: person_track_association_table_core.f
rtl/core/ptat_pkg.sv
rtl/core/ptat_ram.sv
rtl/core/ptat_crowd.sv
rtl/core/person_track_association_table_core.sv
sim/person_track_association_table_core_tb.sv
